@@ src/sofrt_pkg.sv @@
package sofrt_pkg;

    // slot store geometry
    localparam int SLOTS     = 64;
    localparam int SLOT_BITS = $clog2(SLOTS);
    localparam int CNT_BITS  = SLOT_BITS + 1;
    localparam int TIME_BITS = 32;

    // free run scan: one digit of LANES slots per cycle
    localparam int LANES     = 8;
    localparam int LANE_BITS = $clog2(LANES);
    localparam int DIGITS    = SLOTS / LANES;
    localparam int DIG_BITS  = SLOT_BITS - LANE_BITS;

    // field widths fixed by the interface
    localparam int RUN_BITS   = 7;
    localparam int START_BITS = 6;
    localparam int SUM_BITS   = 32;
    localparam int SESS_BITS  = 7;
    localparam int CFG_BITS   = 7;

    localparam logic [SESS_BITS-1:0] SESSION_MAX   = '1;
    localparam logic [CFG_BITS-1:0]  SLOT_CNT_RST  = 7'd64;
    localparam logic [CFG_BITS-1:0]  SESS_LIM_RST  = 7'd100;
    localparam logic [TIME_BITS-1:0] TICK_RST      = TIME_BITS'(1);

    typedef enum logic [1:0] {
        CMD_OCCUPY  = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_TICK    = 2'd2,
        CMD_FINISH  = 2'd3
    } t_cmd;

    typedef enum logic [0:0] {
        CFG_SLOT_COUNT    = 1'b0,
        CFG_SESSION_LIMIT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_cmd                  command;
        logic [SLOT_BITS-1:0]  slot_index;
    } t_in_item;

    typedef struct packed {
        logic [RUN_BITS-1:0]   free_run_length;
        logic [START_BITS-1:0] free_run_start;
        logic                  slot_valid;
        logic [SUM_BITS-1:0]   longest_session;
        logic [SUM_BITS-1:0]   free_run_sum;
        logic [SESS_BITS-1:0]  session_count;
        logic                  done_res;
    } t_out_item;

endpackage

@@ src/slot_occupancy_free_run_tracker_unit.sv @@
// channel  | direction | handshake                 | payload
// ---------+-----------+---------------------------+---------------------------------
// in       | input     | i_in_valid / o_in_ready   | i_in_data  (command, slot_index)
// out      | output    | o_out_valid / i_out_ready | o_out_data (run, counters, done)
// cfg      | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// one transaction at a time: accept, free run scan (8 slots a cycle, LANES sets this),
// apply, then result load
// a stopping command (finish or session limit) adds a sweep of the start tick
// memory, one slot a cycle through its single read port
// reset (synchronous, active low) frees every slot, tick 1, counters zero, cfg to defaults
// the result register is separate: a new transaction is taken while a result waits;
// a stalled output only holds the block at its load step
module slot_occupancy_free_run_tracker_unit (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  sofrt_pkg::t_in_item     i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output sofrt_pkg::t_out_item    o_out_data,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  sofrt_pkg::t_cfg_idx     i_cfg_index,
    input  logic [6:0]              i_cfg_data
);
    import sofrt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_APPLY = 5'b00100,
        S_SWEEP = 5'b01000,
        S_LOAD  = 5'b10000
    } t_state;

    // control state
    t_state                 r_state, n_state;
    logic [CFG_BITS-1:0]    r_slot_count;
    logic [CFG_BITS-1:0]    r_limit;
    logic [SLOTS-1:0]       r_busy, n_busy;
    logic [TIME_BITS-1:0]   r_tick, n_tick;
    logic [SESS_BITS-1:0]   r_sessions, n_sessions;
    logic [SUM_BITS-1:0]    r_run_sum, n_run_sum;
    logic [SUM_BITS-1:0]    r_max, n_max;
    logic                   r_finished, n_finished;
    logic [DIG_BITS-1:0]    r_digit, n_digit;
    logic [CNT_BITS-1:0]    r_sweep, n_sweep;
    logic                   r_out_valid, n_out_valid;

    // per-transaction working registers
    t_cmd                   r_cmd;
    logic [SLOT_BITS-1:0]   r_idx;
    logic [RUN_BITS-1:0]    r_cur, n_cur;
    logic [START_BITS-1:0]  r_cur_start, n_cur_start;
    logic [RUN_BITS-1:0]    r_best, n_best;
    logic [START_BITS-1:0]  r_best_start, n_best_start;
    t_out_item              r_out;

    // session start ticks, written on occupy, read on release and sweep
    logic [TIME_BITS-1:0]   r_start_mem [SLOTS];
    logic [TIME_BITS-1:0]   r_rd_data;
    logic [SLOT_BITS-1:0]   w_rd_addr;
    logic                   w_mem_we;

    logic [CNT_BITS-1:0]    w_live;
    logic                   w_valid;
    logic [TIME_BITS-1:0]   w_dur;
    logic [SUM_BITS:0]      w_sum_wide;
    logic [SLOT_BITS-1:0]   w_sweep_slot;
    logic [SLOT_BITS-1:0]   w_lane_slot [LANES];
    logic                   w_load;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // slot counts above the store size behave as the full store
    assign w_live  = (r_slot_count > CNT_BITS'(SLOTS)) ? CNT_BITS'(SLOTS) : r_slot_count;
    assign w_valid = ({1'b0, r_idx} < w_live);

    // one subtractor serves release and the closing sweep
    assign w_dur        = r_tick - r_rd_data;
    assign w_sum_wide   = {1'b0, r_run_sum} + (SUM_BITS + 1)'(r_best);
    assign w_sweep_slot = SLOT_BITS'(r_sweep - CNT_BITS'(1));
    assign w_rd_addr    = (r_state == S_SWEEP) ? r_sweep[SLOT_BITS-1:0] : r_idx;
    assign w_load       = (r_state == S_LOAD) && (!r_out_valid || i_out_ready);

    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            w_lane_slot[j] = {r_digit, LANE_BITS'(j)};
        end
    end

    // main sequencer
    always_comb begin
        n_state      = r_state;
        n_busy       = r_busy;
        n_tick       = r_tick;
        n_sessions   = r_sessions;
        n_run_sum    = r_run_sum;
        n_max        = r_max;
        n_finished   = r_finished;
        n_digit      = r_digit;
        n_sweep      = r_sweep;
        n_cur        = r_cur;
        n_cur_start  = r_cur_start;
        n_best       = r_best;
        n_best_start = r_best_start;
        n_out_valid  = r_out_valid && !i_out_ready;
        w_mem_we     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state      = S_SCAN;
                    n_digit      = '0;
                    n_cur        = '0;
                    n_cur_start  = '0;
                    n_best       = '0;
                    n_best_start = '0;
                end
            end
            S_SCAN: begin
                // one digit of slots, earliest longest run wins
                for (int j = 0; j < LANES; j++) begin
                    if ({1'b0, w_lane_slot[j]} < w_live) begin
                        if (!r_busy[w_lane_slot[j]]) begin
                            if (n_cur == '0) begin
                                n_cur_start = w_lane_slot[j];
                            end
                            n_cur = n_cur + RUN_BITS'(1);
                            if (n_cur > n_best) begin
                                n_best       = n_cur;
                                n_best_start = n_cur_start;
                            end
                        end else begin
                            n_cur = '0;
                        end
                    end
                end
                n_digit = r_digit + DIG_BITS'(1);
                if (r_digit == DIG_BITS'(DIGITS - 1)) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                n_state = S_LOAD;
                if (!r_finished) begin
                    unique case (r_cmd)
                        CMD_OCCUPY: begin
                            n_run_sum = w_sum_wide[SUM_BITS] ? '1 : w_sum_wide[SUM_BITS-1:0];
                            if (w_valid) begin
                                if (!r_busy[r_idx]) begin
                                    n_busy[r_idx] = 1'b1;
                                    w_mem_we      = 1'b1;
                                end
                                if (r_sessions != SESSION_MAX) begin
                                    n_sessions = r_sessions + SESS_BITS'(1);
                                end
                            end
                        end
                        CMD_RELEASE: begin
                            if (w_valid && r_busy[r_idx]) begin
                                n_busy[r_idx] = 1'b0;
                                if (w_dur > r_max) begin
                                    n_max = w_dur;
                                end
                            end
                        end
                        CMD_TICK: begin
                            n_tick = r_tick + TIME_BITS'(1);
                        end
                        CMD_FINISH: begin
                        end
                        default: begin
                        end
                    endcase
                    if (r_cmd == CMD_FINISH || n_sessions >= r_limit) begin
                        n_state = S_SWEEP;
                        n_sweep = '0;
                    end
                end
            end
            S_SWEEP: begin
                // read data is registered, so it belongs to the previous sweep address
                if (r_sweep != '0 && r_busy[w_sweep_slot] && w_dur > r_max) begin
                    n_max = w_dur;
                end
                n_sweep = r_sweep + CNT_BITS'(1);
                if (r_sweep == CNT_BITS'(SLOTS)) begin
                    n_finished = 1'b1;
                    n_state    = S_LOAD;
                end
            end
            S_LOAD: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_slot_count <= SLOT_CNT_RST;
            r_limit      <= SESS_LIM_RST;
            r_busy       <= '0;
            r_tick       <= TICK_RST;
            r_sessions   <= '0;
            r_run_sum    <= '0;
            r_max        <= '0;
            r_finished   <= 1'b0;
            r_digit      <= '0;
            r_sweep      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_busy      <= n_busy;
            r_tick      <= n_tick;
            r_sessions  <= n_sessions;
            r_run_sum   <= n_run_sum;
            r_max       <= n_max;
            r_finished  <= n_finished;
            r_digit     <= n_digit;
            r_sweep     <= n_sweep;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_SLOT_COUNT:    r_slot_count <= i_cfg_data;
                    CFG_SESSION_LIMIT: r_limit      <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload and scan registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_cmd <= i_in_data.command;
            r_idx <= i_in_data.slot_index;
        end
        r_cur        <= n_cur;
        r_cur_start  <= n_cur_start;
        r_best       <= n_best;
        r_best_start <= n_best_start;
        if (w_load) begin
            r_out.free_run_length <= r_best;
            r_out.free_run_start  <= r_best_start;
            r_out.slot_valid      <= w_valid;
            r_out.longest_session <= r_max;
            r_out.free_run_sum    <= r_run_sum;
            r_out.session_count   <= r_sessions;
            r_out.done_res        <= r_finished;
        end
    end

    // start tick memory
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_start_mem[r_idx] <= r_tick;
        end
        r_rd_data <= r_start_mem[w_rd_addr];
    end

    // checks
    a_finished_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |=> r_finished)
        else $error("finished flag dropped");

    a_run_fits_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> ({1'b0, r_best} <= {1'b0, w_live}))
        else $error("free run longer than live slot count");

    a_empty_run_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD && r_best == '0) |-> (r_best_start == '0))
        else $error("empty free run with non-zero start");

    a_tick_only_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_APPLY) |=> $stable(r_tick))
        else $error("tick moved outside apply step");

    a_sweep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> (r_sweep <= CNT_BITS'(SLOTS)))
        else $error("sweep counter overran");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import sofrt_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 125;

    // clock, reset and every block input start at known values
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    t_in_item   i_in_data   = '0;
    logic       i_out_ready = 1'b0;
    logic       i_cfg_valid = 1'b0;
    t_cfg_idx   i_cfg_index = CFG_SLOT_COUNT;
    logic [6:0] i_cfg_data  = '0;

    logic       o_in_ready;
    logic       o_out_valid;
    t_out_item  o_out_data;
    logic       o_cfg_ready;

    // idling in percent per cycle, changed between phases
    int         idle_pct  = 0;
    int         stall_pct = 0;
    int         cycles    = 0;

    // mirrors the tracker: slot flags, start ticks, counters and both registers,
    // and queues one predicted report per accepted command
    class occupancy_scoreboard;
        logic [63:0] busy;
        logic [31:0] start_tick [64];
        logic [31:0] tick;
        logic [6:0]  sessions;
        logic [31:0] run_sum;
        logic [31:0] longest;
        bit          finished;
        logic [6:0]  slot_count;
        logic [6:0]  session_limit;
        t_out_item   pending_reports [$];
        int          errors;

        function new();
            busy          = '0;
            foreach (start_tick[s]) start_tick[s] = '0;
            tick          = 32'd1;
            sessions      = '0;
            run_sum       = '0;
            longest       = '0;
            finished      = 1'b0;
            slot_count    = 7'd64;
            session_limit = 7'd100;
            errors        = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [6:0] value);
            case (idx)
                CFG_SLOT_COUNT:    slot_count    = value;
                CFG_SESSION_LIMIT: session_limit = value;
                default: ;
            endcase
        endfunction

        // counts above the slot store are clamped to it
        function int live_slots();
            return (slot_count > 7'd64) ? 64 : int'(slot_count);
        endfunction

        function int pending();
            return pending_reports.size();
        endfunction

        // duration wraps with the tick counter
        function void close_session(int s);
            logic [31:0] dur;
            dur = tick - start_tick[s];
            if (dur > longest) longest = dur;
        endfunction

        function void note_command(t_in_item item);
            int          n;
            int          best;
            int          best_at;
            int          run;
            int          run_at;
            bit          ok;
            logic [5:0]  idx;
            logic [32:0] acc;
            t_out_item   want;
            n       = live_slots();
            best    = 0;
            best_at = 0;
            run     = 0;
            run_at  = 0;
            idx     = item.slot_index;
            // earliest longest free run wins, start reported as its true first slot
            for (int i = 0; i < n; i++) begin
                if (!busy[i]) begin
                    if (run == 0) run_at = i;
                    run++;
                    if (run > best) begin
                        best    = run;
                        best_at = run_at;
                    end
                end else begin
                    run = 0;
                end
            end
            ok = (int'(idx) < n);

            if (!finished) begin
                case (item.command)
                    CMD_OCCUPY: begin
                        // every occupy adds to the sum, valid slot or not
                        acc     = {1'b0, run_sum} + 33'(best);
                        run_sum = acc[32] ? '1 : acc[31:0];
                        if (ok) begin
                            // occupying a busy slot still counts a session
                            if (!busy[idx]) begin
                                busy[idx]       = 1'b1;
                                start_tick[idx] = tick;
                            end
                            if (sessions != SESSION_MAX) sessions++;
                        end
                    end
                    CMD_RELEASE: begin
                        if (ok && busy[idx]) begin
                            close_session(int'(idx));
                            busy[idx] = 1'b0;
                        end
                    end
                    CMD_TICK: tick = tick + 32'd1;
                    default: ;
                endcase
                // stop: open sessions closed at the current tick, slots left busy
                if (item.command == CMD_FINISH || sessions >= session_limit) begin
                    for (int s = 0; s < 64; s++)
                        if (busy[s]) close_session(s);
                    finished = 1'b1;
                end
            end

            want.free_run_length = 7'(best);
            want.free_run_start  = 6'(best_at);
            want.slot_valid      = ok;
            want.longest_session = longest;
            want.free_run_sum    = run_sum;
            want.session_count   = sessions;
            want.done_res        = finished;
            pending_reports.push_back(want);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_report(t_out_item got);
            t_out_item want;
            if (pending_reports.size() == 0) begin
                $error("report with no command outstanding");
                errors++;
            end else begin
                want = pending_reports.pop_front();
                compare_field("free_run_length", 32'(want.free_run_length),
                              32'(got.free_run_length));
                compare_field("free_run_start", 32'(want.free_run_start),
                              32'(got.free_run_start));
                compare_field("slot_valid", 32'(want.slot_valid), 32'(got.slot_valid));
                compare_field("longest_session", want.longest_session,
                              got.longest_session);
                compare_field("free_run_sum", want.free_run_sum, got.free_run_sum);
                compare_field("session_count", 32'(want.session_count),
                              32'(got.session_count));
                compare_field("done_res", 32'(want.done_res), 32'(got.done_res));
            end
        endfunction
    endclass

    occupancy_scoreboard sb;

    slot_occupancy_free_run_tracker_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // receiving side: random back-pressure at the current stall rate
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // every result transaction is checked against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_report(o_out_data);
    end

    // watchdog against a hung handshake
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // one command transaction; valid stays high straight into the next one
    // when no gap is drawn, so it is never dropped and raised in one step
    task automatic send_item(t_cmd cmd, logic [5:0] slot);
        t_in_item item;
        item.command    = cmd;
        item.slot_index = slot;
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_command(item);
    endtask

    // sender holds off until every predicted report has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // both registers in back-to-back transactions, only while the block is idle
    task automatic set_config(logic [6:0] count, logic [6:0] limit);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_SLOT_COUNT;
        i_cfg_data  <= count;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(CFG_SLOT_COUNT, count);
        i_cfg_index <= CFG_SESSION_LIMIT;
        i_cfg_data  <= limit;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(CFG_SESSION_LIMIT, limit);
        i_cfg_valid <= 1'b0;
    endtask

    // random command; valid occupies are rationed by budget so the session
    // limit is not hit before the closing phase
    function automatic t_in_item make_item(int budget);
        t_in_item item;
        int       n;
        int       roll;
        int       pick;
        n               = sb.live_slots();
        roll            = $urandom_range(0, 99);
        item.command    = CMD_TICK;
        item.slot_index = 6'($urandom_range(0, 63));
        if (roll < 25) begin
            item.command = CMD_OCCUPY;
            if (n > 0 && $urandom_range(0, 3) != 0)
                item.slot_index = 6'($urandom_range(0, n - 1));
            if (int'(sb.sessions) >= budget && int'(item.slot_index) < n) begin
                if (n < 64) item.slot_index = 6'($urandom_range(n, 63));
                else        item.command    = CMD_RELEASE;
            end
        end else if (roll < 55) begin
            item.command = CMD_RELEASE;
            // mostly aim at a slot in use so sessions actually end
            if (n > 0 && $urandom_range(0, 9) < 7) begin
                for (int k = 0; k < 8; k++) begin
                    pick = $urandom_range(0, n - 1);
                    if (sb.busy[pick]) begin
                        item.slot_index = 6'(pick);
                        break;
                    end
                end
            end
        end
        return item;
    endfunction

    initial begin
        t_in_item   item;
        logic [6:0] counts [PHASES];
        int         stop_mode;
        counts = '{7'd64, 7'd8, 7'd0, 7'd127, 7'd1, 7'd40, 7'd65, 7'd23};
        sb = new();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, on reset register values: busy re-occupy, free release,
        // session end, earliest longest run and a later run's true start
        send_item(CMD_TICK,    6'd0);
        send_item(CMD_OCCUPY,  6'd0);
        send_item(CMD_OCCUPY,  6'd63);
        send_item(CMD_OCCUPY,  6'd0);
        send_item(CMD_TICK,    6'd17);
        send_item(CMD_TICK,    6'd42);
        send_item(CMD_RELEASE, 6'd5);
        send_item(CMD_RELEASE, 6'd0);
        send_item(CMD_OCCUPY,  6'd32);
        send_item(CMD_OCCUPY,  6'd10);
        send_item(CMD_TICK,    6'd0);
        send_item(CMD_RELEASE, 6'd63);
        send_item(CMD_OCCUPY,  6'd62);
        send_item(CMD_RELEASE, 6'd32);
        send_item(CMD_TICK,    6'd63);
        send_item(CMD_RELEASE, 6'd10);
        send_item(CMD_OCCUPY,  6'd1);
        send_item(CMD_RELEASE, 6'd62);

        // random phases over slot counts incl. zero and above the store;
        // idling cycles through none, sender, receiver, both
        for (int p = 0; p < PHASES; p++) begin
            drain();
            set_config(counts[p], 7'd127);
            idle_pct  = (p % 4 == 1) ? 48 : (p % 4 == 3) ? 37 : 0;
            stall_pct = (p % 4 == 2) ? 48 : (p % 4 == 3) ? 37 : 0;
            repeat (PHASE_ITEMS) begin
                item = make_item(10 + 14 * p);
                send_item(item.command, item.slot_index);
            end
        end

        // closing phase: stop by finish, by reaching the limit, or by a zero limit
        drain();
        idle_pct  = 37;
        stall_pct = 37;
        stop_mode = $urandom_range(0, 2);
        case (stop_mode)
            0: send_item(CMD_FINISH, 6'($urandom_range(0, 63)));
            1: begin
                set_config(7'd64, sb.sessions + 7'd2);
                while (!sb.finished) send_item(CMD_OCCUPY, 6'($urandom_range(0, 63)));
            end
            default: begin
                set_config(sb.slot_count, 7'd0);
                item = make_item(0);
                send_item(item.command, item.slot_index);
            end
        endcase

        // once stopped only the run scan and slot check still move
        send_item(CMD_FINISH, 6'd63);
        repeat (9) begin
            item = make_item(0);
            send_item(item.command, item.slot_index);
        end
        drain();
        set_config(7'd127, 7'd1);
        repeat (8) begin
            item = make_item(0);
            send_item(item.command, item.slot_index);
        end
        drain();
        set_config(7'd5, 7'd127);
        repeat (8) begin
            item = make_item(0);
            send_item(item.command, item.slot_index);
        end

        drain();
        // allow for a stray late report after the last expected one
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
